[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Both macros check at the rising edge of i_clk
// and stay quiet while the synchronous reset i_rst_n is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define MTFL_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mtfl assertion failed");

// When the trigger holds, the outcome must hold in the following cycle.
`define MTFL_ASSERT_NEXT(lbl, trig, outcome) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (outcome)) \
        else $error("mtfl assertion failed");

`endif

[hw/rtl/mtfl_pkg.sv]
package mtfl_pkg;

    // Default parameter values for the top level.
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 64;

    // Fixed widths of the request and result fields.
    localparam int KEY_W  = 64;
    localparam int RANK_W = 4;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LIST = 1'b1
    } t_state;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
        logic rotate;
    } t_cell_ctl;

endpackage

[hw/rtl/mtfl_cell.sv]
module mtfl_cell #(
    parameter int KEY_BITS = mtfl_pkg::KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  mtfl_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_BITS-1:0]   i_prev_key,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic [KEY_BITS-1:0]   i_head_key,
    input  logic [KEY_BITS-1:0]   i_cmp_key,
    input  logic                  i_valid,
    input  logic                  i_tail,
    input  logic                  i_hit_in,
    output logic                  o_hit_out,
    output logic [KEY_BITS-1:0]   o_key
);
    import mtfl_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                hit_here;

    // Insert shifts toward the back up to the matching cell; remove and rotate pull from
    // the back neighbor, with the tail cell wrapping around to the head.
    always_comb begin
        hit_here  = i_valid && (r_key == i_cmp_key);
        o_hit_out = i_hit_in | hit_here;
        n_key     = r_key;
        if (i_ctl.insert && !i_hit_in) begin
            n_key = i_prev_key;
        end else if ((i_ctl.remove && o_hit_out) || i_ctl.rotate) begin
            n_key = i_tail ? i_head_key : i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

[hw/rtl/mru_move_to_front_list_core.sv]
// Move-to-front list of the most recently used distinct keys, newest at rank 0. Each rank
// is one cell of a chain; an insert, remove or clear request takes effect as it is taken,
// because every cell compares its key with the request key in parallel and the match
// ripples down the chain as a "hit seen" flag, so all cells shift in the same cycle. A list
// request then walks the list in the cycles after it is taken: the chain rotates by one
// rank per cycle while the output side does not stall and cell 0 feeds the output
// register, so a list of N entries holds off the next request until its walk is done (one
// result for an empty list). Every other request leaves the block idle for the next one.
// After N rotations the list is back in its original order. Capacity is clamped to the
// range 1..DEPTH and lowering it never trims entries already held.
`include "assert_macros.svh"

module mru_move_to_front_list_core #(
    parameter int DEPTH    = mtfl_pkg::DEPTH_DEF,
    parameter int KEY_BITS = mtfl_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [mtfl_pkg::KEY_W-1:0]    i_key,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mtfl_pkg::KEY_W-1:0]    o_entry_key,
    output logic [mtfl_pkg::RANK_W-1:0]   o_entry_rank,
    output logic                          o_is_last,
    output logic                          o_list_empty,
    // Capacity register write.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mtfl_pkg::CAP_W-1:0]    i_cfg_capacity
);
    import mtfl_pkg::*;

    // The count holds 0..DEPTH; capacity compares happen in a width that fits both.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_rank;
    logic [CAP_W-1:0]    r_cap;
    logic [MW-1:0]       cap_eff;
    logic [MW-1:0]       cnt_w;

    logic                r_out_valid;
    logic [KEY_W-1:0]    r_out_key;
    logic [RANK_W-1:0]   r_out_rank;
    logic                r_out_last;
    logic                r_out_empty;

    t_op                 op;
    logic                in_accept;
    logic                out_free;
    logic                emit;
    logic                walk_last;
    logic                any_hit;
    logic [KEY_BITS-1:0] key_in;
    t_cell_ctl           cell_ctl;

    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [DEPTH:0]      hit_chain;

    assign op        = t_op'(i_op);
    assign key_in    = KEY_BITS'(i_key);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign any_hit   = hit_chain[DEPTH];
    assign walk_last = (r_rank == (r_count - CW'(1)));

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 holds the newest key. The hit flag enters cell 0
    // clear and leaves each cell set once any cell at or above it matched.
    // ------------------------------------------------------------------
    assign hit_chain[0] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [KEY_BITS-1:0] prev_key;
        logic [KEY_BITS-1:0] next_key;

        if (gi == 0) begin : g_head
            assign prev_key = key_in;
        end else begin : g_body
            assign prev_key = cell_key[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_end
            assign next_key = cell_key[0];
        end else begin : g_mid
            assign next_key = cell_key[gi+1];
        end

        mtfl_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_prev_key (prev_key),
            .i_next_key (next_key),
            .i_head_key (cell_key[0]),
            .i_cmp_key  (key_in),
            .i_valid    (CW'(gi) < r_count),
            .i_tail     (CW'(gi) == (r_count - CW'(1))),
            .i_hit_in   (hit_chain[gi]),
            .o_hit_out  (hit_chain[gi+1]),
            .o_key      (cell_key[gi])
        );
    end

    // ------------------------------------------------------------------
    // Effective capacity: zero behaves as one, anything above DEPTH as DEPTH.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = MW'(1);
        end else if (MW'(r_cap) > MW'(DEPTH)) begin
            cap_eff = MW'(DEPTH);
        end else begin
            cap_eff = MW'(r_cap);
        end
        cnt_w = MW'(r_count);
    end

    // Entry count. An insert that hits keeps the count unless the list was
    // already over capacity; one that misses grows it only below capacity.
    always_comb begin
        n_count = r_count;
        if (in_accept) begin
            case (op)
                OP_INSERT: begin
                    if (any_hit) begin
                        n_count = ((cnt_w - MW'(1)) >= cap_eff) ? (r_count - CW'(1)) : r_count;
                    end else begin
                        n_count = (cnt_w >= cap_eff) ? r_count : (r_count + CW'(1));
                    end
                end
                OP_REMOVE: begin
                    if (any_hit) begin
                        n_count = r_count - CW'(1);
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: idle takes requests; a list request enters the walk state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (op == OP_LIST)) begin
                    n_state = ST_LIST;
                end
            end
            ST_LIST: begin
                if (emit && ((r_count == '0) || walk_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The input is never stalled while idle, so a valid request there is taken.
    always_comb begin
        o_in_stall      = 1'b1;
        emit            = 1'b0;
        cell_ctl        = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall      = 1'b0;
                cell_ctl.insert = i_in_valid && (op == OP_INSERT);
                cell_ctl.remove = i_in_valid && (op == OP_REMOVE);
            end
            ST_LIST: begin
                emit            = out_free;
                cell_ctl.rotate = out_free && (r_count != '0);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rank      <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (in_accept && (op == OP_LIST)) begin
                r_rank <= '0;
            end else if (emit) begin
                r_rank <= r_rank + CW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_capacity;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register. An empty list yields a single result with all other fields zero.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_count == '0) begin
                r_out_key   <= '0;
                r_out_rank  <= '0;
                r_out_last  <= 1'b0;
                r_out_empty <= 1'b1;
            end else begin
                r_out_key   <= KEY_W'(cell_key[0]);
                r_out_rank  <= RANK_W'(r_rank);
                r_out_last  <= walk_last;
                r_out_empty <= 1'b0;
            end
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_entry_key  = r_out_key;
    assign o_entry_rank = r_out_rank;
    assign o_is_last    = r_out_last;
    assign o_list_empty = r_out_empty;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `MTFL_ASSERT_NOW(a_count_in_range, r_count <= CW'(DEPTH))
    `MTFL_ASSERT_NOW(a_rank_in_list, (r_state != ST_LIST) || (r_count == '0) || (r_rank < r_count))
    `MTFL_ASSERT_NEXT(a_count_frozen_in_walk, r_state == ST_LIST, $stable(r_count))
    `MTFL_ASSERT_NEXT(a_clear_empties, in_accept && (op == OP_CLEAR), r_count == '0)
    `MTFL_ASSERT_NEXT(a_insert_nonempty, in_accept && (op == OP_INSERT), r_count != '0)

endmodule

[tb/tb_mru_move_to_front_list_core.sv]
module tb_mru_move_to_front_list_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mtfl_pkg::*;

    // Register slots of the block. The list never grows past DEPTH_DEF entries.
    localparam int SLOTS = DEPTH_DEF;
    // Cycles allowed after the last expected result before the block counts as idle.
    // Insert, remove and clear act as they are taken, so this margin is plenty.
    localparam int SETTLE_CYCLES = 6;
    // Length of the long receiver hold-off that backs the list walk up into the input.
    localparam int HOLD_CYCLES = 80;
    // Cycles with no request, result or register write accepted before the run is
    // declared hung. The longest legal quiet stretch is the hold-off above.
    localparam int QUIET_LIMIT = 1000;

    // One request as the sender offers it.
    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_mru_req;

    // One list result as the block should produce it.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic              last;
        logic              empty;
    } t_list_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Request channel, driven by the sender below.
    logic             in_valid_r = 1'b0;
    logic [1:0]       op_r = OP_INSERT;
    logic [KEY_W-1:0] key_r = '0;
    logic             o_in_stall;

    // Result channel.
    logic              o_out_valid;
    logic              out_stall_r = 1'b0;
    logic [KEY_W-1:0]  o_entry_key;
    logic [RANK_W-1:0] o_entry_rank;
    logic              o_is_last;
    logic              o_list_empty;

    // Capacity register write channel.
    logic             cfg_valid_r = 1'b0;
    logic [CAP_W-1:0] cfg_cap_r = CAP_RESET;
    logic             o_cfg_ready;

    always #5 i_clk = ~i_clk;

    mru_move_to_front_list_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid_r),
        .o_in_stall     (o_in_stall),
        .i_op           (op_r),
        .i_key          (key_r),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall_r),
        .o_entry_key    (o_entry_key),
        .o_entry_rank   (o_entry_rank),
        .o_is_last      (o_is_last),
        .o_list_empty   (o_list_empty),
        .i_cfg_valid    (cfg_valid_r),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (cfg_cap_r)
    );

    // Requests waiting to be offered, and list results still owed by the block.
    t_mru_req    req_q[$];
    t_list_entry listed_q[$];

    // The expected contents of the list: keys newest first, the number held, and the
    // capacity value last written to the register.
    logic [KEY_W-1:0] held_keys[SLOTS];
    int               held_cnt = 0;
    logic [CAP_W-1:0] held_cap = CAP_RESET;

    // Idle rates in percent for each side, and the hold-off handshake between the
    // stimulus process and the receiver. The receiver serves one hold-off each time
    // the asked count moves ahead of the served count.
    int in_idle_pct = 34;
    int out_idle_pct = 34;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    int mismatch_cnt = 0;
    int quiet_cycles = 0;

    // A random key over all 64 bits, and a small pool of keys that repeat often enough
    // to hit entries already in the list.
    logic [KEY_W-1:0] key_pool[20];

    function automatic logic [KEY_W-1:0] any_key();
        return {$urandom, $urandom};
    endfunction

    // Removes the matching entry, if any, and closes the gap. The list holds distinct
    // keys, so at most one entry can match.
    task automatic drop_key(input logic [KEY_W-1:0] k);
        for (int i = 0; i < held_cnt; i++) begin
            if (held_keys[i] == k) begin
                for (int j = i; j + 1 < held_cnt; j++) begin
                    held_keys[j] = held_keys[j + 1];
                end
                held_cnt--;
                return;
            end
        end
    endtask

    // Applies one accepted request to the expected list and queues any results that
    // it causes. Only a list request produces results.
    task automatic apply_request(input t_op op, input logic [KEY_W-1:0] k);
        int limit;
        case (op)
            OP_INSERT: begin
                drop_key(k);
                // A capacity of zero acts as one, anything past the slot count as
                // the slot count. Lowering the capacity never trims the list at
                // once: each insert drops at most the single oldest entry.
                limit = (held_cap == 0) ? 1 : ((held_cap > SLOTS) ? SLOTS : held_cap);
                if (held_cnt >= limit && held_cnt > 0) begin
                    held_cnt--;
                end
                for (int j = held_cnt; j > 0; j--) begin
                    held_keys[j] = held_keys[j - 1];
                end
                held_keys[0] = k;
                held_cnt++;
            end
            OP_REMOVE: begin
                drop_key(k);
            end
            OP_CLEAR: begin
                held_cnt = 0;
            end
            default: begin
                // A list of an empty list gives a single result flagged empty with
                // every other field zero.
                if (held_cnt == 0) begin
                    listed_q.push_back('{key: '0, rank: '0, last: 1'b0, empty: 1'b1});
                end else begin
                    for (int i = 0; i < held_cnt; i++) begin
                        listed_q.push_back('{key: held_keys[i], rank: RANK_W'(i),
                                             last: (i + 1 == held_cnt), empty: 1'b0});
                    end
                end
            end
        endcase
    endtask

    // Sender. The next request is picked only once the current one is gone, so a
    // stalled request keeps its fields and valid never looks at the stall.
    always @(posedge i_clk) begin
        t_mru_req nxt;
        logic     taken;
        if (!i_rst_n) begin
            in_valid_r <= 1'b0;
        end else begin
            taken = in_valid_r && !o_in_stall;
            if (taken) begin
                apply_request(t_op'(op_r), key_r);
            end
            if (!in_valid_r || taken) begin
                if (req_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                    nxt = req_q.pop_front();
                    in_valid_r <= 1'b1;
                    op_r <= nxt.op;
                    key_r <= nxt.key;
                end else begin
                    in_valid_r <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input logic [KEY_W-1:0] want,
                                input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: list result %s mismatch: expected %h, actual %h",
                     $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Receiver. Every accepted result is checked against the oldest one still owed,
    // then the stall for the next cycle is chosen: a requested hold-off first, else
    // random idling at the current rate.
    always @(posedge i_clk) begin
        t_list_entry want;
        if (!i_rst_n) begin
            out_stall_r <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall_r) begin
                if (listed_q.size() == 0) begin
                    $display("%0t: unexpected list result: expected none, actual key %h",
                             $time, o_entry_key);
                    $display("    rank %0d last %b empty %b",
                             o_entry_rank, o_is_last, o_list_empty);
                    mismatch_cnt++;
                end else begin
                    want = listed_q.pop_front();
                    report_field("entry_key", want.key, o_entry_key);
                    report_field("entry_rank", KEY_W'(want.rank), KEY_W'(o_entry_rank));
                    report_field("is_last", KEY_W'(want.last), KEY_W'(o_is_last));
                    report_field("list_empty", KEY_W'(want.empty), KEY_W'(o_list_empty));
                end
            end
            if (hold_left == 0 && hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall_r <= 1'b1;
            end else begin
                out_stall_r <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    // Counts cycles in which no handshake of any channel completes.
    always @(posedge i_clk) begin
        if ((in_valid_r && !o_in_stall) || (o_out_valid && !out_stall_r)
                || (cfg_valid_r && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("mru_move_to_front_list_core verification failed");
        $finish;
    end

    task automatic push_req(input t_op op, input logic [KEY_W-1:0] k);
        req_q.push_back('{op: op, key: k});
    endtask

    // Waits until every request has been taken and every owed result has come out,
    // then waits out the settle margin so the last insert, remove or clear has settled.
    task automatic wait_idle();
        while (req_q.size() > 0 || in_valid_r || listed_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the capacity register once the block is idle. The expected capacity is
    // updated at the edge that completes the write.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        @(posedge i_clk);
        cfg_valid_r <= 1'b1;
        cfg_cap_r <= cap;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        held_cap = cap;
        cfg_valid_r <= 1'b0;
    endtask

    // Queues a batch of random requests. Most keys come from the pool so that inserts
    // hit and reorder entries and removes find something; the rest are fresh keys
    // that exercise every key bit.
    task automatic queue_random(input int count, input int list_pct);
        int               roll;
        t_op              op;
        logic [KEY_W-1:0] k;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < list_pct) begin
                op = OP_LIST;
            end else if (roll < list_pct + 4) begin
                op = OP_CLEAR;
            end else if (roll < list_pct + 24) begin
                op = OP_REMOVE;
            end else begin
                op = OP_INSERT;
            end
            if ($urandom_range(99) < 75) begin
                k = key_pool[$urandom_range(19)];
            end else begin
                k = any_key();
            end
            push_req(op, k);
        end
    endtask

    initial begin
        for (int i = 0; i < 20; i++) begin
            key_pool[i] = any_key();
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests at the reset capacity: a list of the empty list, the all
        // zero and all one keys, an insert that hits an existing entry and moves it to
        // the front, a remove that misses, one that hits, clear, and a remove that
        // empties the list.
        push_req(OP_LIST, '0);
        push_req(OP_INSERT, '0);
        push_req(OP_INSERT, '1);
        push_req(OP_INSERT, 64'hA5A5_A5A5_5A5A_5A5A);
        push_req(OP_INSERT, '0);
        push_req(OP_LIST, '1);
        push_req(OP_REMOVE, 64'h0000_0000_0000_1234);
        push_req(OP_REMOVE, '1);
        push_req(OP_LIST, '0);
        push_req(OP_CLEAR, '1);
        push_req(OP_LIST, '0);
        push_req(OP_INSERT, 64'h5A5A_5A5A_A5A5_A5A5);
        push_req(OP_REMOVE, 64'h5A5A_5A5A_A5A5_A5A5);
        push_req(OP_LIST, '0);

        // Smallest capacity: every insert of a new key replaces the only entry.
        write_capacity(5'd1);
        push_req(OP_INSERT, key_pool[2]);
        push_req(OP_INSERT, key_pool[3]);
        push_req(OP_LIST, '0);

        // A capacity of zero behaves as one.
        write_capacity(5'd0);
        push_req(OP_INSERT, key_pool[4]);
        push_req(OP_INSERT, key_pool[3]);
        push_req(OP_LIST, '0);

        // Capacity above the slot count behaves as the slot count.
        write_capacity(5'd31);
        queue_random(40, 22);

        // A stretch with no idling on either side.
        write_capacity(5'd16);
        in_idle_pct = 0;
        out_idle_pct = 0;
        queue_random(40, 26);
        wait_idle();
        in_idle_pct = 34;
        out_idle_pct = 34;

        // The receiver holds off for a long stretch while list-heavy traffic keeps
        // coming, so the walk backs up and the block stalls its input.
        hold_asked++;
        queue_random(30, 50);

        // Lowering the capacity below the count leaves the list as it is; each later
        // insert drops at most the single oldest entry.
        write_capacity(5'd5);
        queue_random(40, 26);
        write_capacity(5'd2);
        queue_random(40, 26);
        write_capacity(5'd9);
        queue_random(40, 26);
        write_capacity(5'd1);
        queue_random(30, 26);
        write_capacity(5'd16);
        queue_random(10, 26);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (mismatch_cnt == 0 && listed_q.size() == 0) begin
            $display("mru_move_to_front_list_core verification clean");
        end else begin
            $display("mru_move_to_front_list_core verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mtfl_pkg.sv
hw/rtl/mtfl_cell.sv
hw/rtl/mru_move_to_front_list_core.sv
tb/tb_mru_move_to_front_list_core.sv
